// File: rtl/fpalu_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Shared types, operation codes and defaults for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpalu_pkg;

	localparam int FRAC_BITS_DEF = 8;
	localparam int DATA_W        = 32;

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_MIN      = 4'd4,
		OP_MAX      = 4'd5,
		OP_INC      = 4'd6,
		OP_DEC      = 4'd7,
		OP_TO_INT   = 4'd8,
		OP_FROM_INT = 4'd9
	} op_t;

	typedef struct packed {
		logic        [3:0]        operation;
		logic signed [DATA_W-1:0] operand_a;
		logic signed [DATA_W-1:0] operand_b;
	} request_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_value;
		logic                     a_less;
		logic                     a_equal;
		logic                     a_greater;
		logic                     divide_by_zero;
	} response_t;

	// Side information that rides along with the divider stages.
	typedef struct packed {
		logic        [3:0]        operation;
		logic        [DATA_W-1:0] result;
		logic                     lt;
		logic                     eq;
		logic                     gt;
		logic                     neg;
		logic                     dbz;
	} tag_t;

endpackage

// File: rtl/fpalu_div.sv
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage, with a tag
// carried alongside each transaction.
// ----------------------------------------------------------------------------
module fpalu_div #(
	parameter int NUM_W = 40,
	parameter int DEN_W = 32,
	parameter int TAG_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid,
	input  logic [NUM_W-1:0] numerator,
	input  logic [DEN_W-1:0] denominator,
	input  logic [TAG_W-1:0] tag,
	output logic             done,
	output logic [NUM_W-1:0] quotient,
	output logic [TAG_W-1:0] tag_out
);

	logic             valid_s [0:NUM_W];
	logic [NUM_W-1:0] nq_s    [0:NUM_W];
	logic [DEN_W-1:0] rem_s   [0:NUM_W];
	logic [DEN_W-1:0] den_s   [0:NUM_W];
	logic [TAG_W-1:0] tag_s   [0:NUM_W];

	assign valid_s[0] = valid;
	assign nq_s[0]    = numerator;
	assign rem_s[0]   = '0;
	assign den_s[0]   = denominator;
	assign tag_s[0]   = tag;

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic [DEN_W:0] shifted;
		logic [DEN_W:0] diff;
		logic           ge;

		always_comb begin
			shifted = {rem_s[i], nq_s[i][NUM_W-1]};
			diff    = shifted - {1'b0, den_s[i]};
			ge      = shifted >= {1'b0, den_s[i]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else begin
				valid_s[i+1] <= valid_s[i];
			end
		end

		// The numerator shifts out at the top while quotient bits fill the bottom.
		always_ff @(posedge clk) begin
			nq_s[i+1]  <= {nq_s[i][NUM_W-2:0], ge};
			rem_s[i+1] <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			den_s[i+1] <= den_s[i];
			tag_s[i+1] <= tag_s[i];
		end
	end

	assign done     = valid_s[NUM_W];
	assign quotient = nq_s[NUM_W];
	assign tag_out  = tag_s[NUM_W];

endmodule

// File: rtl/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU
// Signed 32-bit fixed-point arithmetic with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// A transaction is taken in every cycle that start is high; busy is always
// low. Every transaction returns one result, flagged by done for one cycle,
// in the order issued. Each passes the request register, the stage-2
// registers, the divider stages and the response register; the divider
// resolves one quotient bit per stage over the 32 + FRAC_BITS numerator
// bits; every operation shares that pipeline. The block cannot be stalled.
module fixed_point_alu #(
	parameter int FRAC_BITS = fpalu_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  fpalu_pkg::request_t   request,
	output logic                  done,
	output fpalu_pkg::response_t  response
);

	import fpalu_pkg::*;

	localparam int NUM_W = DATA_W + FRAC_BITS;
	localparam int TAG_W = $bits(tag_t);

	logic                       valid_s1;
	request_t                   req_s1;
	logic                       valid_s2;
	logic signed [2*DATA_W-1:0] prod_s2;
	tag_t                       tag_s2;
	logic        [DATA_W-1:0]   ma_s2;
	logic        [DATA_W-1:0]   mb_s2;

	logic signed [DATA_W-1:0]   a;
	logic signed [DATA_W-1:0]   b;
	logic        [DATA_W-1:0]   simple;
	tag_t                       tag_c;
	logic signed [2*DATA_W-1:0] prod_shift;
	tag_t                       div_tag_in;
	logic        [TAG_W-1:0]    div_tag_raw;
	tag_t                       div_tag;
	logic                       div_done;
	logic        [NUM_W-1:0]    div_q;
	logic        [DATA_W-1:0]   q_low;
	logic        [DATA_W-1:0]   final_res;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		req_s1 <= request;
	end

	always_comb begin
		a = req_s1.operand_a;
		b = req_s1.operand_b;
		case (req_s1.operation)
			OP_ADD:      simple = a + b;
			OP_SUB:      simple = a - b;
			OP_MIN:      simple = (a < b) ? a : b;
			OP_MAX:      simple = (a > b) ? a : b;
			OP_INC:      simple = a + 32'sd1;
			OP_DEC:      simple = a - 32'sd1;
			OP_TO_INT:   simple = a >>> FRAC_BITS;
			OP_FROM_INT: simple = a << FRAC_BITS;
			default:     simple = '0;
		endcase
		tag_c.operation = req_s1.operation;
		tag_c.result    = simple;
		tag_c.lt        = a < b;
		tag_c.eq        = a == b;
		tag_c.gt        = a > b;
		tag_c.neg       = a[DATA_W-1] ^ b[DATA_W-1];
		tag_c.dbz       = (req_s1.operation == OP_DIV) && (b == '0);
	end

	always_ff @(posedge clk) begin
		prod_s2 <= 64'(a) * 64'(b);
		tag_s2  <= tag_c;
		ma_s2   <= a[DATA_W-1] ? (DATA_W'(0) - a) : a;
		mb_s2   <= b[DATA_W-1] ? (DATA_W'(0) - b) : b;
	end

	// The multiply result is merged here; only a constant shift remains.
	always_comb begin
		prod_shift = prod_s2 >>> FRAC_BITS;
		div_tag_in = tag_s2;
		if (tag_s2.operation == OP_MUL) begin
			div_tag_in.result = prod_shift[DATA_W-1:0];
		end
	end

	fpalu_div #(
		.NUM_W(NUM_W),
		.DEN_W(DATA_W),
		.TAG_W(TAG_W)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (valid_s2),
		.numerator  (NUM_W'(ma_s2) << FRAC_BITS),
		.denominator(mb_s2),
		.tag        (div_tag_in),
		.done       (div_done),
		.quotient   (div_q),
		.tag_out    (div_tag_raw)
	);

	always_comb begin
		div_tag = tag_t'(div_tag_raw);
		q_low   = div_q[DATA_W-1:0];
		if (div_tag.operation == OP_DIV) begin
			if (div_tag.dbz) begin
				final_res = '0;
			end else if (div_tag.neg) begin
				final_res = DATA_W'(0) - q_low;
			end else begin
				final_res = q_low;
			end
		end else begin
			final_res = div_tag.result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= div_done;
		end
	end

	always_ff @(posedge clk) begin
		response.result_value   <= final_res;
		response.a_less         <= div_tag.lt;
		response.a_equal        <= div_tag.eq;
		response.a_greater      <= div_tag.gt;
		response.divide_by_zero <= div_tag.dbz;
	end

endmodule
